// ----- rtl/vstg_pkg.sv -----
// vstg_pkg: shared types, constants and the glyph stroke rom for the
// vector stroke text generator; no dependencies
package vstg_pkg;

  // stroke limit per glyph and the hard output limit
  localparam int MAX_STROKES  = 8;
  localparam int OUT_LIMIT    = 8;
  localparam int STROKE_LIMIT = (MAX_STROKES < OUT_LIMIT) ? MAX_STROKES : OUT_LIMIT;

  localparam logic [23:0] REVEAL_ALL = 24'hFFFFFF;
  localparam int STATE_W = 32;
  localparam int STATE_DEPTH = 2;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_ORIGIN_X  = 3'd0,
    REG_ORIGIN_Y  = 3'd1,
    REG_SCALE     = 3'd2,
    REG_REVEAL    = 3'd3,
    REG_GWIDTH    = 3'd4,
    REG_LEAD_BYTE = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_EMIT,
    ST_ADV
  } vstg_state_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       text_start;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] x_from;
    logic signed [15:0] y_from;
    logic signed [15:0] x_to;
    logic signed [15:0] y_to;
    logic [15:0]        stroke_number;
    logic               last_of_char;
  } out_word_t;

  // first stage of one segment, handed to the segment unit
  typedef struct packed {
    logic signed [17:0] xf;
    logic signed [17:0] yf;
    logic               dx_neg;
    logic [14:0]        dx_mag;
    logic               dy_neg;
    logic [14:0]        dy_mag;
    logic [8:0]         part;
    logic [15:0]        idx;
    logic               last;
  } seg_calc_t;

  // strokes as nibbles gx0 gy0 gx1 gy1, signed, first stroke leftmost
  typedef struct packed {
    logic [3:0]         cnt;
    logic [0:7][15:0]   pts;
  } glyph_t;

  function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
    logic signed [15:0] r;
    if (v > 19'sd32767) r = 16'sh7FFF;
    else if (v < -19'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  // glyph lookup on an already folded code; count 0 means unknown
  function automatic glyph_t glyph_rom(input logic [7:0] code);
    glyph_t g;
    g.cnt = 4'd0;
    g.pts = '0;
    case (code)
      8'h30: begin g.cnt = 4'd5; g.pts = 128'h0004_0424_2420_2000_0024_0000_0000_0000; end
      8'h31: begin g.cnt = 4'd2; g.pts = 128'h1014_0111_0000_0000_0000_0000_0000_0000; end
      8'h32: begin g.cnt = 4'd5; g.pts = 128'h0020_2022_2202_0204_0424_0000_0000_0000; end
      8'h33: begin g.cnt = 4'd4; g.pts = 128'h0020_2024_2404_1222_0000_0000_0000_0000; end
      8'h34: begin g.cnt = 4'd3; g.pts = 128'h0002_0222_2024_0000_0000_0000_0000_0000; end
      8'h35, 8'h53: begin
        g.cnt = 4'd5; g.pts = 128'h2000_0002_0222_2224_2404_0000_0000_0000;
      end
      8'h36: begin g.cnt = 4'd5; g.pts = 128'h2000_0004_0424_2422_2202_0000_0000_0000; end
      8'h37: begin g.cnt = 4'd2; g.pts = 128'h0020_2004_0000_0000_0000_0000_0000_0000; end
      8'h38: begin g.cnt = 4'd5; g.pts = 128'h0020_0004_2024_0424_0222_0000_0000_0000; end
      8'h39: begin g.cnt = 4'd4; g.pts = 128'h2000_0002_0222_2024_0000_0000_0000_0000; end
      8'h41: begin g.cnt = 4'd5; g.pts = 128'h0401_0110_1021_2124_0222_0000_0000_0000; end
      8'h42: begin g.cnt = 4'd7; g.pts = 128'h0004_0020_2022_2202_0222_2224_2404_0000; end
      8'h43: begin g.cnt = 4'd3; g.pts = 128'h2000_0004_0424_0000_0000_0000_0000_0000; end
      8'h44: begin g.cnt = 4'd6; g.pts = 128'h0004_0010_1031_3133_3314_1404_0000_0000; end
      8'h45: begin g.cnt = 4'd4; g.pts = 128'h2000_0004_0424_0212_0000_0000_0000_0000; end
      // accented e: last stroke reaches into the accent rows
      8'h89: begin g.cnt = 4'd5; g.pts = 128'h2000_0004_0424_0212_1F2E_0000_0000_0000; end
      8'h46: begin g.cnt = 4'd3; g.pts = 128'h2000_0004_0212_0000_0000_0000_0000_0000; end
      8'h47: begin g.cnt = 4'd5; g.pts = 128'h2000_0004_0424_2422_2212_0000_0000_0000; end
      8'h48: begin g.cnt = 4'd3; g.pts = 128'h0004_2024_0222_0000_0000_0000_0000_0000; end
      8'h49: begin g.cnt = 4'd3; g.pts = 128'h0020_1014_0424_0000_0000_0000_0000_0000; end
      8'h4A: begin g.cnt = 4'd3; g.pts = 128'h2022_2214_1404_0000_0000_0000_0000_0000; end
      8'h4B: begin g.cnt = 4'd3; g.pts = 128'h0004_2002_0224_0000_0000_0000_0000_0000; end
      8'h4C: begin g.cnt = 4'd2; g.pts = 128'h0004_0424_0000_0000_0000_0000_0000_0000; end
      8'h4D: begin g.cnt = 4'd4; g.pts = 128'h0400_0012_1220_2024_0000_0000_0000_0000; end
      8'h4E: begin g.cnt = 4'd3; g.pts = 128'h0400_0024_2420_0000_0000_0000_0000_0000; end
      8'h4F: begin g.cnt = 4'd4; g.pts = 128'h0020_2024_2404_0400_0000_0000_0000_0000; end
      8'h50: begin g.cnt = 4'd4; g.pts = 128'h0400_0020_2022_2202_0000_0000_0000_0000; end
      8'h51: begin g.cnt = 4'd5; g.pts = 128'h0020_2024_2404_0400_1324_0000_0000_0000; end
      8'h52: begin g.cnt = 4'd5; g.pts = 128'h0400_0020_2022_2202_0224_0000_0000_0000; end
      8'h54: begin g.cnt = 4'd2; g.pts = 128'h0020_1014_0000_0000_0000_0000_0000_0000; end
      8'h55: begin g.cnt = 4'd3; g.pts = 128'h0004_0424_2420_0000_0000_0000_0000_0000; end
      8'h56: begin g.cnt = 4'd2; g.pts = 128'h0014_1420_0000_0000_0000_0000_0000_0000; end
      8'h57: begin g.cnt = 4'd4; g.pts = 128'h0004_0412_1224_2420_0000_0000_0000_0000; end
      8'h58: begin g.cnt = 4'd2; g.pts = 128'h0024_2004_0000_0000_0000_0000_0000_0000; end
      8'h59: begin g.cnt = 4'd3; g.pts = 128'h0012_2012_1214_0000_0000_0000_0000_0000; end
      8'h5A: begin g.cnt = 4'd3; g.pts = 128'h0020_2004_0424_0000_0000_0000_0000_0000; end
      8'h2D: begin g.cnt = 4'd1; g.pts = 128'h0222_0000_0000_0000_0000_0000_0000_0000; end
      8'h2E: begin g.cnt = 4'd1; g.pts = 128'h1414_0000_0000_0000_0000_0000_0000_0000; end
      8'h2F: begin g.cnt = 4'd1; g.pts = 128'h0420_0000_0000_0000_0000_0000_0000_0000; end
      default: begin g.cnt = 4'd0; g.pts = '0; end
    endcase
    return g;
  endfunction

endpackage

// ----- rtl/vstg_ram.sv -----
// vstg_ram: generic single port ram with registered read
// no dependencies
module vstg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- rtl/vstg_seg.sv -----
// vstg_seg: second stage of a segment: partial end scaling, rounding, saturation
// depends on vstg_pkg
module vstg_seg (
  input  vstg_pkg::seg_calc_t calc,
  output vstg_pkg::out_word_t word
);

  logic [23:0]        mx, my;
  logic [24:0]        rx_sum, ry_sum;
  logic [15:0]        rx, ry;
  logic signed [18:0] xt, yt;

  // magnitude times part, rounded half away from zero
  always_comb begin
    mx = calc.dx_mag * calc.part;
    my = calc.dy_mag * calc.part;
    rx_sum = {1'b0, mx} + 25'd128;
    ry_sum = {1'b0, my} + 25'd128;
    rx = rx_sum[23:8];
    ry = ry_sum[23:8];
    xt = calc.dx_neg ? (19'(calc.xf) - $signed({3'b0, rx}))
                     : (19'(calc.xf) + $signed({3'b0, rx}));
    yt = calc.dy_neg ? (19'(calc.yf) - $signed({3'b0, ry}))
                     : (19'(calc.yf) + $signed({3'b0, ry}));
  end

  // saturated output word
  always_comb begin
    word.x_from        = vstg_pkg::sat16(19'(calc.xf));
    word.y_from        = vstg_pkg::sat16(19'(calc.yf));
    word.x_to          = vstg_pkg::sat16(xt);
    word.y_to          = vstg_pkg::sat16(yt);
    word.stroke_number = calc.idx;
    word.last_of_char  = calc.last;
  end

endmodule

// ----- rtl/vector_stroke_text_generator.sv -----
// vector_stroke_text_generator: top level, sequencer and config registers
// depends on vstg_pkg, vstg_ram, vstg_seg
//
// Usage: one text byte per input word (in_valid/in_stall, in_word). Each
// byte produces 0..7 segment words on out_valid/out_stall/out_word, the
// last one flagged with last_of_char. A text_start byte restarts the pen at
// origin_x and the stroke number at 0. Configuration is written through
// cfg_we/cfg_idx/cfg_wdata while the block is idle.
// Sequence: the pen and stroke count live in entry 0 of a two-entry state
// ram read at accept; a byte passes through read and glyph lookup, then
// per stroke a setup and, for an emitted segment, an output load (a
// dropped stroke gets only the setup), then write back, before the next
// byte can be accepted. One byte is in work at a time; in_stall is high
// from accept until write back.
// Results sit in an output register; while it holds a word and out_stall
// is high the sequencer holds the next segment and waits. Reset clears pen
// and count to zero, loads register defaults and drops any word in the
// output register.
module vector_stroke_text_generator (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  vstg_pkg::in_word_t   in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output vstg_pkg::out_word_t  out_word,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_idx,
  input  logic [23:0]          cfg_wdata
);

  // configuration registers
  logic signed [15:0] origin_x_r, origin_y_r;
  logic [11:0]        scale_r;
  logic [23:0]        reveal_r;
  logic [2:0]         gwidth_r;
  logic [7:0]         lead_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      scale_r    <= 12'd16;
      reveal_r   <= vstg_pkg::REVEAL_ALL;
      gwidth_r   <= 3'd3;
      lead_r     <= 8'd195;
    end else if (cfg_we) begin
      unique case (vstg_pkg::cfg_reg_t'(cfg_idx))
        vstg_pkg::REG_ORIGIN_X:  origin_x_r <= cfg_wdata[15:0];
        vstg_pkg::REG_ORIGIN_Y:  origin_y_r <= cfg_wdata[15:0];
        vstg_pkg::REG_SCALE:     scale_r    <= cfg_wdata[11:0];
        vstg_pkg::REG_REVEAL:    reveal_r   <= cfg_wdata;
        vstg_pkg::REG_GWIDTH:    gwidth_r   <= cfg_wdata[2:0];
        vstg_pkg::REG_LEAD_BYTE: lead_r     <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // state ram: {stroke_count, pen_x} in entry 0
  localparam int AW = $clog2(vstg_pkg::STATE_DEPTH);
  logic                          ram_we;
  logic [vstg_pkg::STATE_W-1:0]  ram_wdata, ram_rdata;
  logic                          ram_vld_r, ram_vld_nxt;

  vstg_ram #(.WIDTH(vstg_pkg::STATE_W), .DEPTH(vstg_pkg::STATE_DEPTH)) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  ({AW{1'b0}}),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // sequencer registers
  vstg_pkg::vstg_state_t state_r, state_nxt;
  logic [7:0]         code_r, code_nxt;
  logic               start_r, start_nxt;
  logic signed [15:0] pen_r, pen_nxt;
  logic [15:0]        cnt_r, cnt_nxt;
  vstg_pkg::glyph_t   glyph_r, glyph_nxt;
  logic [3:0]         n_r, n_nxt;
  logic [2:0]         k_r, k_nxt;
  logic               skip_r, skip_nxt;
  vstg_pkg::seg_calc_t calc_r, calc_nxt;
  logic               out_valid_r, out_valid_nxt;
  vstg_pkg::out_word_t out_word_r, out_word_nxt;
  vstg_pkg::out_word_t seg_word;

  vstg_seg u_seg (
    .calc (calc_r),
    .word (seg_word)
  );

  // lookup, stroke setup and pen advance datapath
  logic [7:0]         fold;
  logic [15:0]        stk;
  logic signed [3:0]  gx0, gy0, gx1, gy1;
  logic signed [12:0] s13;
  logic signed [16:0] px0, py0;
  logic signed [4:0]  gdx, gdy;
  logic signed [17:0] dx, dy, dx_abs, dy_abs;
  logic               all_drawn, drop, next_drop, last_k;
  logic [23:0]        idx_sh, next_sh, diff;
  logic [15:0]        next_idx;
  logic [15:0]        adv;
  logic signed [18:0] pen_sum;

  always_comb begin
    fold = (code_r >= 8'h61 && code_r <= 8'h7A) ? (code_r - 8'd32) : code_r;
    stk  = glyph_r.pts[k_r];
    gx0  = stk[15:12];
    gy0  = stk[11:8];
    gx1  = stk[7:4];
    gy1  = stk[3:0];
    s13  = $signed({1'b0, scale_r});
    px0  = gx0 * s13;
    py0  = gy0 * s13;
    gdx  = {gx1[3], gx1} - {gx0[3], gx0};
    gdy  = {gy1[3], gy1} - {gy0[3], gy0};
    dx   = gdx * s13;
    dy   = gdy * s13;
    dx_abs = dx[17] ? -dx : dx;
    dy_abs = dy[17] ? -dy : dy;
    all_drawn = (reveal_r == vstg_pkg::REVEAL_ALL);
    idx_sh    = {cnt_r, 8'h00};
    next_idx  = (cnt_r == 16'hFFFF) ? cnt_r : (cnt_r + 16'd1);
    next_sh   = {next_idx, 8'h00};
    drop      = !all_drawn && (idx_sh >= reveal_r);
    next_drop = !all_drawn && (next_sh >= reveal_r);
    diff      = reveal_r - idx_sh;
    last_k    = ({1'b0, k_r} == (n_r - 4'd1));
    adv       = ({1'b0, gwidth_r} + 4'd1) * scale_r;
    pen_sum   = 19'(pen_r) + $signed({3'b0, adv});
  end

  // sequencer next state and outputs
  always_comb begin
    state_nxt     = state_r;
    code_nxt      = code_r;
    start_nxt     = start_r;
    pen_nxt       = pen_r;
    cnt_nxt       = cnt_r;
    glyph_nxt     = glyph_r;
    n_nxt         = n_r;
    k_nxt         = k_r;
    skip_nxt      = skip_r;
    calc_nxt      = calc_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    ram_vld_nxt   = ram_vld_r;
    ram_we        = 1'b0;
    ram_wdata     = {cnt_r, pen_r};
    in_stall      = (state_r != vstg_pkg::ST_IDLE);

    // output register drains when taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      vstg_pkg::ST_IDLE: begin
        if (in_valid) begin
          code_nxt  = in_word.char_code;
          start_nxt = in_word.text_start;
          state_nxt = vstg_pkg::ST_READ;
        end
      end
      vstg_pkg::ST_READ: begin
        if (start_r) begin
          pen_nxt = origin_x_r;
          cnt_nxt = '0;
        end else if (ram_vld_r) begin
          pen_nxt = ram_rdata[15:0];
          cnt_nxt = ram_rdata[31:16];
        end else begin
          pen_nxt = '0;
          cnt_nxt = '0;
        end
        glyph_nxt = vstg_pkg::glyph_rom(fold);
        n_nxt = (glyph_nxt.cnt > 4'(vstg_pkg::STROKE_LIMIT)) ?
                4'(vstg_pkg::STROKE_LIMIT) : glyph_nxt.cnt;
        k_nxt    = '0;
        skip_nxt = (code_r == lead_r);
        if (code_r == lead_r || n_nxt == 4'd0) begin
          state_nxt = vstg_pkg::ST_ADV;
        end else begin
          state_nxt = vstg_pkg::ST_CALC;
        end
      end
      vstg_pkg::ST_CALC: begin
        calc_nxt.xf     = 18'(pen_r) + 18'(px0);
        calc_nxt.yf     = 18'(origin_y_r) + 18'(py0);
        calc_nxt.dx_neg = dx[17];
        calc_nxt.dx_mag = dx_abs[14:0];
        calc_nxt.dy_neg = dy[17];
        calc_nxt.dy_mag = dy_abs[14:0];
        calc_nxt.part   = (all_drawn || diff >= 24'd256) ? 9'd256 : diff[8:0];
        calc_nxt.idx    = cnt_r;
        calc_nxt.last   = last_k || next_drop;
        cnt_nxt         = next_idx;
        if (!drop) begin
          state_nxt = vstg_pkg::ST_EMIT;
        end else if (last_k) begin
          state_nxt = vstg_pkg::ST_ADV;
        end else begin
          k_nxt = k_r + 3'd1;
        end
      end
      vstg_pkg::ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = seg_word;
          if (last_k) begin
            state_nxt = vstg_pkg::ST_ADV;
          end else begin
            k_nxt     = k_r + 3'd1;
            state_nxt = vstg_pkg::ST_CALC;
          end
        end
      end
      vstg_pkg::ST_ADV: begin
        // write back, pen advances unless this was the lead byte
        ram_we      = 1'b1;
        ram_wdata   = {cnt_r, skip_r ? pen_r : vstg_pkg::sat16(pen_sum)};
        ram_vld_nxt = 1'b1;
        state_nxt   = vstg_pkg::ST_IDLE;
      end
      default: state_nxt = vstg_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vstg_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      ram_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ram_vld_r   <= ram_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    code_r     <= code_nxt;
    start_r    <= start_nxt;
    pen_r      <= pen_nxt;
    cnt_r      <= cnt_nxt;
    glyph_r    <= glyph_nxt;
    n_r        <= n_nxt;
    k_r        <= k_nxt;
    skip_r     <= skip_nxt;
    calc_r     <= calc_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
